// ===== hdl/fractal_gradient_noise_defines.svh =====
// Assertion helpers shared by the fractal noise block.
`ifndef FRACTAL_GRADIENT_NOISE_DEFINES_SVH
`define FRACTAL_GRADIENT_NOISE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FGN_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FGN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fgn_pkg.sv =====
package fgn_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int MAX_OCTAVES    = 16;
  localparam int FRONT_DEPTH    = 4;
  localparam int OUT_DEPTH      = 2;
  // Width of per-octave noise values and of the fractal accumulator
  localparam int NW    = 24;
  localparam int ACC_W = 48;
  localparam logic [31:0] CELL_OFFSET = 32'h0000_1000;
  // 3.0 in Q16
  localparam logic [17:0] FADE_THREE  = 18'h30000;

  typedef enum logic [2:0] {
    REQ_EVAL    = 3'd0,
    REQ_LOAD_P  = 3'd1,
    REQ_LOAD_1D = 3'd2,
    REQ_LOAD_2D = 3'd3,
    REQ_LOAD_3D = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    CFG_OCTAVES = 2'd0,
    CFG_FREQ    = 2'd1,
    CFG_AMP     = 2'd2,
    CFG_DIM     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [4:0]  octaves;
    logic [31:0] base_freq;
    logic [31:0] base_amp;
    logic [1:0]  dim_count;
  } fgn_cfg_t;

  typedef struct packed {
    req_t               op;
    logic [7:0]         index;
    logic [7:0]         perm;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } fgn_item_t;

  typedef struct packed {
    logic signed [31:0] noise;
    logic               sat;
  } fgn_res_t;

  typedef struct packed {
    logic item_pop;
    logic res_push;
    logic busy;
  } fgn_evst_t;

endpackage

// ===== hdl/fgn_fifo.sv =====
module fgn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/fgn_front.sv =====
module fgn_front import fgn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_req_type,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_perm_value,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic signed [15:0] in_grad_z,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  input  logic signed [31:0] in_z_coord,
  output fgn_item_t          item_o,
  output logic               item_empty_o,
  input  logic               item_pop_i
);

  fgn_item_t              item;
  logic                   known;
  logic [$bits(fgn_item_t)-1:0] rdata;

  // Drop unknown request codes here; they never reach the back end.
  assign known = (in_req_type == REQ_EVAL) || (in_req_type == REQ_LOAD_P) ||
                 (in_req_type == REQ_LOAD_1D) || (in_req_type == REQ_LOAD_2D) ||
                 (in_req_type == REQ_LOAD_3D);

  always_comb begin
    item.op    = req_t'(in_req_type);
    item.index = in_table_index;
    item.perm  = in_perm_value;
    item.gx    = in_grad_x;
    item.gy    = in_grad_y;
    item.gz    = in_grad_z;
    item.x     = in_x_coord;
    item.y     = in_y_coord;
    item.z     = in_z_coord;
  end

  fgn_fifo #(
    .WIDTH ($bits(fgn_item_t)),
    .DEPTH (FRONT_DEPTH)
  ) u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && known),
    .wdata (item),
    .full  (in_full),
    .pop   (item_pop_i),
    .rdata (rdata),
    .empty (item_empty_o)
  );

  assign item_o = fgn_item_t'(rdata);

endmodule

// ===== hdl/fgn_eval.sv =====
module fgn_eval import fgn_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  fgn_cfg_t  cfg_i,
  input  fgn_item_t item_i,
  input  logic      item_empty_i,
  input  logic      res_full_i,
  output fgn_res_t  res_o,
  output fgn_evst_t st_o
);

  localparam int IW = $clog2(TABLE_SIZE);
  typedef logic [IW-1:0] idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_FADE, S_PI, S_PJ, S_PW, S_HOP, S_HOPW,
    S_CORNER, S_DOT, S_REDUCE, S_LERP, S_AMP, S_DONE
  } state_t;

  function automatic idx_t wrap8(logic [7:0] v);
    logic [IW+7:0] e;
    e = {{IW{1'b0}}, v};
    return e[IW-1:0];
  endfunction

  function automatic idx_t add_idx(logic [7:0] p, idx_t c);
    logic [IW+7:0] s;
    s = {{IW{1'b0}}, p} + {8'd0, c};
    return s[IW-1:0];
  endfunction

  function automatic idx_t cell_of(logic [47:0] c);
    logic [31:0] s;
    s = c[47:16] + CELL_OFFSET;
    return s[IW-1:0];
  endfunction

  // Tables
  logic [7:0]  perm_mem [TABLE_SIZE];
  logic [15:0] g1_mem   [TABLE_SIZE];
  logic [31:0] g2_mem   [TABLE_SIZE];
  logic [47:0] g3_mem   [TABLE_SIZE];
  logic [7:0]  perm_q;
  logic [15:0] g1_q;
  logic [31:0] g2_q;
  logic [47:0] g3_q;

  state_t                state_r;
  logic [47:0]           crd_r  [3];
  logic [16:0]           fade_r [3];
  logic [15:0]           t2_r;
  logic [7:0]            pi_r, pj_r;
  logic [7:0]            hop_r  [4];
  logic signed [NW-1:0]  cur_r;
  logic signed [NW-1:0]  hold_r [3];
  logic signed [35:0]    dacc_r;
  logic [1:0]            step_r;
  logic                  sub_r;
  logic [1:0]            lv_r;
  logic [2:0]            corner_r;
  logic [31:0]           amp_r;
  logic [5:0]            oct_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [1:0]  dim;
  logic [5:0]  oct_lim;
  idx_t        xc0, xc1, yc0, yc1, zc0, zc1;
  idx_t        wa, perm_ra, grad_ra;
  logic        load, perm_re, grad_re;
  logic [16:0] tq;
  logic signed [16:0] r_sel;
  logic signed [15:0] g_sel;
  logic signed [NW:0] diff;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p, mul_sh;
  logic signed [35:0] dot_sum, dot_sh;
  logic signed [31:0] coord_sel;
  logic signed [ACC_W-1:0] acc_max, acc_min;

  assign dim     = (cfg_i.dim_count == 2'd0) ? 2'd1 : cfg_i.dim_count;
  assign oct_lim = ({1'b0, cfg_i.octaves} > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES)
                                                             : {1'b0, cfg_i.octaves};

  // Lattice cells of the current octave; table size is a power of two
  assign xc0 = cell_of(crd_r[0]);
  assign yc0 = cell_of(crd_r[1]);
  assign zc0 = cell_of(crd_r[2]);
  assign xc1 = xc0 + 1'b1;
  assign yc1 = yc0 + 1'b1;
  assign zc1 = zc0 + 1'b1;

  // Table loads
  assign load = (state_r == S_IDLE) && !item_empty_i;
  assign wa   = wrap8(item_i.index);

  always_ff @(posedge clk) begin
    if (load && item_i.op == REQ_LOAD_P) begin
      perm_mem[wa] <= item_i.perm;
    end
    if (perm_re) begin
      perm_q <= perm_mem[perm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (load && item_i.op == REQ_LOAD_1D) begin
      g1_mem[wa] <= item_i.gx;
    end
    if (grad_re) begin
      g1_q <= g1_mem[grad_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (load && item_i.op == REQ_LOAD_2D) begin
      g2_mem[wa] <= {item_i.gy, item_i.gx};
    end
    if (grad_re) begin
      g2_q <= g2_mem[grad_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (load && item_i.op == REQ_LOAD_3D) begin
      g3_mem[wa] <= {item_i.gz, item_i.gy, item_i.gx};
    end
    if (grad_re) begin
      g3_q <= g3_mem[grad_ra];
    end
  end

  // Read addresses
  assign perm_re = (state_r == S_PI) || (state_r == S_PJ) || (state_r == S_HOP);
  assign grad_re = (state_r == S_CORNER);

  always_comb begin
    case (state_r)
      S_PJ:    perm_ra = xc1;
      S_HOP:   perm_ra = add_idx(step_r[0] ? pj_r : pi_r, step_r[1] ? yc1 : yc0);
      default: perm_ra = xc0;
    endcase
  end

  always_comb begin
    case (dim)
      2'd1:    grad_ra = wrap8(corner_r[0] ? pj_r : pi_r);
      2'd2:    grad_ra = wrap8(hop_r[corner_r[1:0]]);
      default: grad_ra = add_idx(hop_r[corner_r[1:0]], corner_r[2] ? zc1 : zc0);
    endcase
  end

  // Operand selection for the shared multiplier
  assign tq = {1'b0, crd_r[step_r][15:0]};

  always_comb begin
    case (step_r)
      2'd0:    r_sel = {corner_r[0], crd_r[0][15:0]};
      2'd1:    r_sel = {corner_r[1], crd_r[1][15:0]};
      default: r_sel = {corner_r[2], crd_r[2][15:0]};
    endcase
  end

  always_comb begin
    case (dim)
      2'd1:    g_sel = g1_q;
      2'd2:    g_sel = step_r[0] ? g2_q[31:16] : g2_q[15:0];
      default: begin
        case (step_r)
          2'd0:    g_sel = g3_q[15:0];
          2'd1:    g_sel = g3_q[31:16];
          default: g_sel = g3_q[47:32];
        endcase
      end
    endcase
  end

  always_comb begin
    case (step_r)
      2'd0:    coord_sel = item_i.x;
      2'd1:    coord_sel = item_i.y;
      default: coord_sel = item_i.z;
    endcase
  end

  assign diff = {cur_r[NW-1], cur_r} - {hold_r[lv_r][NW-1], hold_r[lv_r]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SCALE: begin
        mul_a = {{2{coord_sel[31]}}, coord_sel};
        mul_b = {2'b00, cfg_i.base_freq};
      end
      S_FADE: begin
        if (!sub_r) begin
          mul_a = {17'd0, tq};
          mul_b = {17'd0, tq};
        end else begin
          mul_a = {18'd0, t2_r};
          mul_b = {16'd0, FADE_THREE - {tq, 1'b0}};
        end
      end
      S_DOT: begin
        mul_a = {{17{r_sel[16]}}, r_sel};
        mul_b = {{18{g_sel[15]}}, g_sel};
      end
      S_LERP: begin
        mul_a = {17'd0, fade_r[lv_r]};
        mul_b = {{(33 - NW){diff[NW]}}, diff};
      end
      S_AMP: begin
        mul_a = {{(34 - NW){cur_r[NW-1]}}, cur_r};
        mul_b = {2'b00, amp_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_sh  = mul_p >>> 16;
  assign dot_sum = dacc_r + mul_p[35:0];
  assign dot_sh  = dot_sum >>> 15;

  // Sequencer: one multiply per cycle, one table read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!item_empty_i && item_i.op == REQ_EVAL) begin
            step_r  <= 2'd0;
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          crd_r[step_r] <= mul_p[63:16];
          if (step_r == 2'd2) begin
            amp_r   <= cfg_i.base_amp;
            acc_r   <= '0;
            oct_r   <= oct_lim;
            step_r  <= 2'd0;
            sub_r   <= 1'b0;
            state_r <= (oct_lim == 6'd0) ? S_DONE : S_FADE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_FADE: begin
          if (!sub_r) begin
            t2_r  <= mul_p[31:16];
            sub_r <= 1'b1;
          end else begin
            fade_r[step_r] <= mul_p[32:16];
            sub_r          <= 1'b0;
            if (step_r == 2'd2) begin
              step_r  <= 2'd0;
              state_r <= S_PI;
            end else begin
              step_r <= step_r + 1'b1;
            end
          end
        end
        S_PI: begin
          state_r <= S_PJ;
        end
        S_PJ: begin
          pi_r    <= perm_q;
          state_r <= S_PW;
        end
        S_PW: begin
          pj_r     <= perm_q;
          corner_r <= 3'd0;
          step_r   <= 2'd0;
          state_r  <= (dim == 2'd1) ? S_CORNER : S_HOP;
        end
        S_HOP: begin
          state_r <= S_HOPW;
        end
        S_HOPW: begin
          hop_r[step_r] <= perm_q;
          step_r        <= step_r + 1'b1;
          state_r       <= (step_r == 2'd3) ? S_CORNER : S_HOP;
        end
        S_CORNER: begin
          dacc_r  <= '0;
          step_r  <= 2'd0;
          lv_r    <= 2'd0;
          state_r <= S_DOT;
        end
        S_DOT: begin
          if (step_r == dim - 2'd1) begin
            cur_r   <= dot_sh[NW-1:0];
            state_r <= S_REDUCE;
          end else begin
            dacc_r <= dot_sum;
            step_r <= step_r + 1'b1;
          end
        end
        S_REDUCE: begin
          if (lv_r == dim) begin
            state_r <= S_AMP;
          end else if (!corner_r[lv_r]) begin
            hold_r[lv_r] <= cur_r;
            corner_r     <= corner_r + 1'b1;
            state_r      <= S_CORNER;
          end else begin
            state_r <= S_LERP;
          end
        end
        S_LERP: begin
          cur_r   <= hold_r[lv_r] + mul_sh[NW-1:0];
          lv_r    <= lv_r + 1'b1;
          state_r <= S_REDUCE;
        end
        S_AMP: begin
          acc_r    <= acc_r + mul_sh[ACC_W-1:0];
          crd_r[0] <= {crd_r[0][46:0], 1'b0};
          crd_r[1] <= {crd_r[1][46:0], 1'b0};
          crd_r[2] <= {crd_r[2][46:0], 1'b0};
          amp_r    <= amp_r >> 1;
          oct_r    <= oct_r - 1'b1;
          step_r   <= 2'd0;
          sub_r    <= 1'b0;
          state_r  <= (oct_r == 6'd1) ? S_DONE : S_FADE;
        end
        S_DONE: begin
          if (!res_full_i) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Clip the sum to Q16.16
  assign acc_max = {{(ACC_W - 31){1'b0}}, {31{1'b1}}};
  assign acc_min = {{(ACC_W - 31){1'b1}}, 31'd0};

  always_comb begin
    res_o.sat   = (acc_r > acc_max) || (acc_r < acc_min);
    if (acc_r > acc_max) begin
      res_o.noise = 32'sh7FFF_FFFF;
    end else if (acc_r < acc_min) begin
      res_o.noise = 32'sh8000_0000;
    end else begin
      res_o.noise = acc_r[31:0];
    end
  end

  assign st_o.item_pop = (load && item_i.op != REQ_EVAL) ||
                         (state_r == S_SCALE && step_r == 2'd2);
  assign st_o.res_push = (state_r == S_DONE) && !res_full_i;
  assign st_o.busy     = (state_r != S_IDLE);

endmodule

// ===== hdl/fractal_gradient_noise.sv =====
// Fractal gradient noise engine (Perlin noise summed over octaves, Q16.16).
// Input queue: drive the in_ fields and raise in_push; a transaction is
// taken on a clock edge where in_full is low. Load transactions fill the
// permutation table and the 1D/2D/3D gradient tables; evaluate transactions
// produce one result. Unknown request codes are taken and dropped.
// Result queue: while out_empty is low the oldest result sits on
// out_noise_value/out_saturated; raise out_pop to take it.
// Loads retire one per cycle while the back end is idle. An evaluate
// occupies the back end, which has a single shared multiplier and
// single-port table reads; the input queue (4 deep) keeps accepting
// while it works.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 octaves, 1 frequency, 2 amplitude, 3 dimensions); write only when idle.
// Reset (synchronous, rst_n low) empties both queues and restores config
// defaults; table contents are undefined until loaded.
// A stalled receiver fills the 2-deep result queue; the evaluator then holds
// its finished result and the input queue backs up until in_full rises.
`include "fractal_gradient_noise_defines.svh"

module fractal_gradient_noise import fgn_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_req_type,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_perm_value,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic signed [15:0] in_grad_z,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  input  logic signed [31:0] in_z_coord,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_noise_value,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  fgn_cfg_t  cfg_r;
  fgn_item_t item;
  logic      item_empty;
  fgn_res_t  res;
  fgn_res_t  res_q;
  fgn_evst_t st;
  logic      res_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.octaves   <= 5'd1;
      cfg_r.base_freq <= 32'h0001_0000;
      cfg_r.base_amp  <= 32'h0001_0000;
      cfg_r.dim_count <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OCTAVES: cfg_r.octaves   <= cfg_data[4:0];
        CFG_FREQ:    cfg_r.base_freq <= cfg_data;
        CFG_AMP:     cfg_r.base_amp  <= cfg_data;
        CFG_DIM:     cfg_r.dim_count <= cfg_data[1:0];
        default:     cfg_r <= cfg_r;
      endcase
    end
  end

  // Front end: classify and queue incoming transactions
  fgn_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_table_index (in_table_index),
    .in_perm_value  (in_perm_value),
    .in_grad_x      (in_grad_x),
    .in_grad_y      (in_grad_y),
    .in_grad_z      (in_grad_z),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_z_coord     (in_z_coord),
    .item_o         (item),
    .item_empty_o   (item_empty),
    .item_pop_i     (st.item_pop)
  );

  // Back end: table writes and octave evaluation
  fgn_eval #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_eval (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg_r),
    .item_i       (item),
    .item_empty_i (item_empty),
    .res_full_i   (res_full),
    .res_o        (res),
    .st_o         (st)
  );

  // Result queue decouples the evaluator from the receiver
  fgn_fifo #(
    .WIDTH ($bits(fgn_res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (st.res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_q),
    .empty (out_empty)
  );

  assign out_noise_value = res_q.noise;
  assign out_saturated   = res_q.sat;

  `FGN_ASSERT_IMPLY(a_no_res_overflow, st.res_push, !res_full, "result pushed into full queue")
  `FGN_ASSERT_IMPLY(a_pop_has_item, st.item_pop, !item_empty, "back end popped an empty queue")
  `FGN_ASSERT_NEXT(a_push_then_idle, st.res_push, !st.busy, "evaluator busy after result")

endmodule

// ===== tb/sv/fgn_noise_checker.sv =====
module fgn_noise_checker import fgn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [2:0]         in_req_type,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_perm_value,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic signed [15:0] in_grad_z,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  input  logic signed [31:0] in_z_coord,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [31:0] out_noise_value,
  input  logic               out_saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct {
    logic [7:0] c0;
    logic [7:0] c1;
    longint     r0;
    longint     r1;
  } lattice_t;

  logic [7:0]         perm_tab[256];
  logic signed [15:0] g1_tab[256];
  logic signed [15:0] g2x_tab[256], g2y_tab[256];
  logic signed [15:0] g3x_tab[256], g3y_tab[256], g3z_tab[256];

  logic [4:0]  octaves;
  logic [31:0] freq;
  logic [31:0] amp0;
  logic [1:0]  dims;

  fgn_res_t noise_q[$];

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic lattice_t split_axis(logic [63:0] c);
    lattice_t   s;
    logic [31:0] w;
    w = c[47:16] + CELL_OFFSET;
    s.c0 = w[7:0];
    s.c1 = w[7:0] + 8'd1;
    s.r0 = longint'({48'd0, c[15:0]});
    s.r1 = s.r0 - 65536;
    return s;
  endfunction

  function automatic longint fade_q(longint t);
    longint t2;
    t2 = (t * t) >>> 16;
    return (t2 * (196608 - 2 * t)) >>> 16;
  endfunction

  function automatic longint lerp_q(longint t, longint a, longint b);
    return a + ((t * (b - a)) >>> 16);
  endfunction

  function automatic logic [7:0] hop(logic [7:0] p, logic [7:0] c);
    return perm_tab[8'(p + c)];
  endfunction

  function automatic longint dot2(logic [7:0] k, longint rx, longint ry);
    return (rx * longint'(g2x_tab[k]) + ry * longint'(g2y_tab[k])) >>> 15;
  endfunction

  function automatic longint dot3(logic [7:0] k, longint rx, longint ry, longint rz);
    return (rx * longint'(g3x_tab[k]) + ry * longint'(g3y_tab[k])
            + rz * longint'(g3z_tab[k])) >>> 15;
  endfunction

  function automatic longint noise_1d(logic [63:0] cx);
    lattice_t x;
    longint   u, v;
    x = split_axis(cx);
    u = (x.r0 * longint'(g1_tab[perm_tab[x.c0]])) >>> 15;
    v = (x.r1 * longint'(g1_tab[perm_tab[x.c1]])) >>> 15;
    return lerp_q(fade_q(x.r0), u, v);
  endfunction

  function automatic longint noise_2d(logic [63:0] cx, logic [63:0] cy);
    lattice_t   x, y;
    logic [7:0] i, j;
    longint     sx, a, b;
    x = split_axis(cx);
    y = split_axis(cy);
    i = perm_tab[x.c0];
    j = perm_tab[x.c1];
    sx = fade_q(x.r0);
    a = lerp_q(sx, dot2(hop(i, y.c0), x.r0, y.r0), dot2(hop(j, y.c0), x.r1, y.r0));
    b = lerp_q(sx, dot2(hop(i, y.c1), x.r0, y.r1), dot2(hop(j, y.c1), x.r1, y.r1));
    return lerp_q(fade_q(y.r0), a, b);
  endfunction

  function automatic longint noise_3d(logic [63:0] cx, logic [63:0] cy, logic [63:0] cz);
    lattice_t   x, y, z;
    logic [7:0] i, j, b00, b10, b01, b11;
    longint     sx, sy, a, b, lo, hi;
    x = split_axis(cx);
    y = split_axis(cy);
    z = split_axis(cz);
    i = perm_tab[x.c0];
    j = perm_tab[x.c1];
    b00 = hop(i, y.c0);
    b10 = hop(j, y.c0);
    b01 = hop(i, y.c1);
    b11 = hop(j, y.c1);
    sx = fade_q(x.r0);
    sy = fade_q(y.r0);
    a = lerp_q(sx, dot3(8'(b00 + z.c0), x.r0, y.r0, z.r0),
                   dot3(8'(b10 + z.c0), x.r1, y.r0, z.r0));
    b = lerp_q(sx, dot3(8'(b01 + z.c0), x.r0, y.r1, z.r0),
                   dot3(8'(b11 + z.c0), x.r1, y.r1, z.r0));
    lo = lerp_q(sy, a, b);
    a = lerp_q(sx, dot3(8'(b00 + z.c1), x.r0, y.r0, z.r1),
                   dot3(8'(b10 + z.c1), x.r1, y.r0, z.r1));
    b = lerp_q(sx, dot3(8'(b01 + z.c1), x.r0, y.r1, z.r1),
                   dot3(8'(b11 + z.c1), x.r1, y.r1, z.r1));
    hi = lerp_q(sy, a, b);
    return lerp_q(fade_q(z.r0), lo, hi);
  endfunction

  function automatic fgn_res_t fractal_sum(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z);
    logic [63:0] cx, cy, cz;
    longint      acc, amp, n;
    int          oct;
    fgn_res_t    r;
    cx = 64'((longint'(x) * longint'(freq)) >>> 16);
    cy = 64'((longint'(y) * longint'(freq)) >>> 16);
    cz = 64'((longint'(z) * longint'(freq)) >>> 16);
    amp = longint'(amp0);
    oct = (octaves > MAX_OCTAVES) ? MAX_OCTAVES : int'(octaves);
    acc = 0;
    for (int k = 0; k < oct; k++) begin
      if (dims == 2'd3) n = noise_3d(cx, cy, cz);
      else if (dims == 2'd2) n = noise_2d(cx, cy);
      else n = noise_1d(cx);
      acc += (n * amp) >>> 16;
      cx = cx << 1;
      cy = cy << 1;
      cz = cz << 1;
      amp = amp >>> 1;
    end
    r.sat = 1'b1;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    else r.sat = 1'b0;
    r.noise = 32'(acc);
    return r;
  endfunction

  always @(posedge clk) begin
    fgn_res_t want;
    if (!rst_n) begin
      octaves = 5'd1;
      freq = 32'h0001_0000;
      amp0 = 32'h0001_0000;
      dims = 2'd3;
      noise_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_OCTAVES: octaves = cfg_data[4:0];
          CFG_FREQ:    freq = cfg_data;
          CFG_AMP:     amp0 = cfg_data;
          CFG_DIM:     dims = cfg_data[1:0];
          default: ;
        endcase
      end
      // Compare the result first: a new evaluate can't be its own answer.
      if (out_pop && !out_empty) begin
        if (noise_q.size() == 0) begin
          report_mismatch("unexpected result", out_noise_value, 0);
        end else begin
          want = noise_q.pop_front();
          if (out_noise_value !== want.noise)
            report_mismatch("noise_value", out_noise_value, want.noise);
          if (out_saturated !== want.sat)
            report_mismatch("saturated", out_saturated, want.sat);
        end
      end
      // Apply loads in acceptance order so each evaluate sees the right tables.
      if (in_push && !in_full) begin
        case (req_t'(in_req_type))
          REQ_EVAL:    noise_q.push_back(fractal_sum(in_x_coord, in_y_coord, in_z_coord));
          REQ_LOAD_P:  perm_tab[in_table_index] = in_perm_value;
          REQ_LOAD_1D: g1_tab[in_table_index] = in_grad_x;
          REQ_LOAD_2D: begin
            g2x_tab[in_table_index] = in_grad_x;
            g2y_tab[in_table_index] = in_grad_y;
          end
          REQ_LOAD_3D: begin
            g3x_tab[in_table_index] = in_grad_x;
            g3y_tab[in_table_index] = in_grad_y;
            g3z_tab[in_table_index] = in_grad_z;
          end
          default: ;
        endcase
      end
    end
    outstanding <= noise_q.size();
  end

  initial mismatches = 0;

endmodule

// ===== tb/sv/fractal_gradient_noise_tb.sv =====
module fractal_gradient_noise_tb;
  import fgn_pkg::*;

  // Longest evaluate is 16 octaves of 3D noise, plus a long receiver stall;
  // allow many times that with nothing moving.
  localparam int QUIET_LIMIT = 20000;
  // Settle time once every result has come back: loads may still sit
  // in the 4-deep input queue; dropped transactions never enter it.
  localparam int DRAIN_CYCLES = 30;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [2:0]         in_req_type = REQ_LOAD_P;
  logic [7:0]         in_table_index = '0;
  logic [7:0]         in_perm_value = '0;
  logic signed [15:0] in_grad_x = '0;
  logic signed [15:0] in_grad_y = '0;
  logic signed [15:0] in_grad_z = '0;
  logic signed [31:0] in_x_coord = '0;
  logic signed [31:0] in_y_coord = '0;
  logic signed [31:0] in_z_coord = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [31:0] out_noise_value;
  logic               out_saturated;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_OCTAVES;
  logic [31:0]        cfg_data = '0;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  bit steady = 1'b0;     // when set, neither side idles
  int pop_hold = 0;

  always #1 clk = ~clk;

  fractal_gradient_noise DUT (.*);

  fgn_noise_checker checker_i (.*);

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  // Receiver: hold pop low for a random stall now and then.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      out_pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) pop_hold <= gap_len();
    end
  end

  // Watchdog: count cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Drive one transaction and hold it until accepted, then maybe idle.
  task automatic send(fgn_item_t it);
    int gap;
    in_req_type <= it.op;
    in_table_index <= it.index;
    in_perm_value <= it.perm;
    in_grad_x <= it.gx;
    in_grad_y <= it.gy;
    in_grad_z <= it.gz;
    in_x_coord <= it.x;
    in_y_coord <= it.y;
    in_z_coord <= it.z;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    gap = gap_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_grad();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'(-$urandom_range(0, 3));
      3, 4, 5: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      default: return 32'($urandom);
    endcase
  endfunction

  // Every field is random; only the request code is steered.
  function automatic fgn_item_t rand_item();
    fgn_item_t it;
    int r;
    it.index = 8'($urandom);
    it.perm = 8'($urandom);
    it.gx = rand_grad();
    it.gy = rand_grad();
    it.gz = rand_grad();
    it.x = rand_coord();
    it.y = rand_coord();
    it.z = rand_coord();
    r = $urandom_range(0, 99);
    if (r < 65) it.op = REQ_EVAL;
    else if (r < 75) it.op = REQ_LOAD_P;
    else if (r < 80) it.op = REQ_LOAD_1D;
    else if (r < 85) it.op = REQ_LOAD_2D;
    else if (r < 93) it.op = REQ_LOAD_3D;
    else it.op = req_t'(3'($urandom_range(5, 7)));
    return it;
  endfunction

  // Wait for every result, let the input queue drain, then write all registers.
  task automatic set_config(logic [4:0] oct, logic [31:0] freq, logic [31:0] amp,
                            logic [1:0] dim);
    logic [31:0] vals[4];
    vals = '{32'(oct), freq, amp, 32'(dim)};
    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count);
    repeat (count) send(rand_item());
  endtask

  initial begin
    fgn_item_t it;
    logic signed [31:0] edges[6];
    edges = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1, 32'sh0000_FFFF,
              32'sh0001_0000};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every table entry so no evaluate ever reads an unwritten one.
    steady = 1'b1;
    for (int i = 0; i < 256; i++) begin
      it = rand_item();
      it.index = 8'(i);
      it.op = REQ_LOAD_P;
      send(it);
      it.op = REQ_LOAD_1D;
      send(it);
      it.op = REQ_LOAD_2D;
      send(it);
      it.op = REQ_LOAD_3D;
      send(it);
    end
    steady = 1'b0;

    // Directed, with the reset config: coordinate extremes, then dropped codes.
    for (int i = 0; i < 6; i++) begin
      it = rand_item();
      it.op = REQ_EVAL;
      it.x = edges[i];
      it.y = edges[5 - i];
      it.z = edges[(i + 2) % 6];
      send(it);
    end
    for (int c = 5; c <= 7; c++) begin
      it = rand_item();
      it.op = req_t'(3'(c));
      send(it);
    end

    // Zero octaves gives zero; dimension zero behaves as 1D; octave count above
    // the maximum is clipped; full-scale frequency and amplitude saturate.
    set_config(5'd0, 32'h0001_0000, 32'h0001_0000, 2'd3);
    run_random(8);
    set_config(5'd31, 32'h0000_8000, 32'h0001_0000, 2'd0);
    run_random(8);
    set_config(5'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd2);
    run_random(10);
    set_config(5'd16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    run_random(5);
    set_config(5'd1, 32'h0000_0000, 32'h0000_0000, 2'd1);
    run_random(6);

    // Random phases, mostly few octaves to keep the run short.
    for (int p = 0; p < 8; p++) begin
      steady = (p % 5 == 2);
      set_config($urandom_range(0, 9) == 0 ? 5'($urandom) : 5'($urandom_range(0, 4)),
                 $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 32'h0004_0000)),
                 32'($urandom), 2'($urandom));
      run_random(16);
    end
    steady = 1'b0;

    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/fgn_pkg.sv
hdl/fgn_fifo.sv
hdl/fgn_front.sv
hdl/fgn_eval.sv
hdl/fractal_gradient_noise.sv
tb/sv/fgn_noise_checker.sv
tb/sv/fractal_gradient_noise_tb.sv
